@@ rtl/core/qmfm_pkg.sv @@
// ----------------------------------------------------------------------------
// qmfm_pkg
// Shared types and constants of the quadrotor force mixer: item layouts,
// register indexes, fixed-point constants and pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package qmfm_pkg;

  // arithmetic widths
  localparam int unsigned FORCE_W     = 52;   // signed Q.24 force
  localparam int unsigned DIV_W       = 56;   // dividend and quotient
  localparam int unsigned DIVR_W      = 32;   // divisor and remainder
  localparam int unsigned DIV_STAGES  = DIV_W;
  localparam int unsigned RAD_W       = 60;   // radicand, Q.40
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned SQRT_STAGES = ROOT_W;
  localparam int unsigned F16_W       = 34;   // capped force in Q.16
  localparam int unsigned BB_W        = 40;   // b*b >> 8

  // fixed-point constants
  localparam logic [31:0]              SQRT_HALF_Q32 = 32'd3037000500;
  localparam logic signed [FORCE_W-1:0] FORCE_CAP    = FORCE_W'(64'd2199023255552);
  localparam logic [23:0]              DRIVE_MAX     = 24'hFFFFFF;

  // register reset values
  localparam logic [15:0] ARM_LENGTH_RST       = 16'd5374;
  localparam logic [23:0] THRUST_TO_TORQUE_RST = 24'd100071;
  localparam logic [23:0] CURVE_QUADRATIC_RST  = 24'd1534992;
  localparam logic [23:0] CURVE_LINEAR_RST     = 24'd1135376;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ARM_LENGTH       = 2'd0,
    REG_THRUST_TO_TORQUE = 2'd1,
    REG_CURVE_QUADRATIC  = 2'd2,
    REG_CURVE_LINEAR     = 2'd3
  } cfg_reg_t;

  // input item
  typedef struct packed {
    logic        [23:0] thrust;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [23:0] drive_front_left;
    logic [23:0] drive_rear_left;
    logic [23:0] drive_rear_right;
    logic [23:0] drive_front_right;
    logic [3:0]  clamped_mask;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/qmfm_div.sv @@
// ----------------------------------------------------------------------------
// qmfm_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qmfm_div
  import qmfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   out_valid,
  output logic [DIV_W-1:0]       quotient
);

  logic              vld_r [DIV_STAGES];
  logic [DIVR_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_W-1:0]  dq_r  [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic              v_in;
    logic [DIVR_W-1:0] rem_in;
    logic [DIV_W-1:0]  dq_in;
    logic [DIVR_W:0]   trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign dq_in  = dividend;
    end else begin : g_next
      assign v_in   = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign dq_in  = dq_r[i-1];
    end

    // shift in next dividend bit and try subtracting
    assign trial = {rem_in, dq_in[DIV_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? DIVR_W'(trial - {1'b0, divisor}) : trial[DIVR_W-1:0];
      dq_r[i]  <= {dq_in[DIV_W-2:0], ge};
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign quotient  = dq_r[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/qmfm_sqrt.sv @@
// ----------------------------------------------------------------------------
// qmfm_sqrt
// Pipelined floor square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qmfm_sqrt
  import qmfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      root
);

  logic              vld_r  [SQRT_STAGES];
  logic [31:0]       rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic              v_in;
    logic [31:0]       rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [33:0]       cur;
    logic [33:0]       trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign v_in    = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    // bring down two bits, test root*4+1
    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = 34'({root_in, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? 32'(cur - trial) : cur[31:0];
      root_r[i] <= {root_in[ROOT_W-2:0], ge};
      rad_r[i]  <= {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign root      = root_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/qmfm_curve.sv @@
// ----------------------------------------------------------------------------
// qmfm_curve
// One motor lane: clamp the force and invert the quadratic thrust curve.
// ----------------------------------------------------------------------------
`default_nettype none

module qmfm_curve
  import qmfm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic signed [FORCE_W-1:0] force_in,
  input  wire logic [23:0]               curve_a,
  input  wire logic [23:0]               curve_b,
  input  wire logic [BB_W-1:0]           bb8,
  output logic                           out_valid,
  output logic [23:0]                    drive,
  output logic                           clamped
);

  // clamp, cap and reduce to Q.16
  logic             c1_vld_r;
  logic             c1_neg_r;
  logic [F16_W-1:0] c1_f16_r;
  logic [FORCE_W-1:0] capped;

  always_comb begin
    if (force_in < 0) begin
      capped = '0;
    end else if (force_in > FORCE_CAP) begin
      capped = FORCE_CAP;
    end else begin
      capped = force_in;
    end
  end

  // a * F16
  logic        c2_vld_r;
  logic        c2_neg_r;
  logic [57:0] c2_prod_r;

  // radicand
  logic             c3_vld_r;
  logic             c3_neg_r;
  logic [RAD_W-1:0] c3_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= in_valid;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_neg_r  <= force_in[FORCE_W-1];
    c1_f16_r  <= capped[F16_W+7:8];
    c2_neg_r  <= c1_neg_r;
    c2_prod_r <= 58'(curve_a) * 58'(c1_f16_r);
    c3_neg_r  <= c2_neg_r;
    c3_rad_r  <= RAD_W'(bb8) + {c2_prod_r, 2'b00};
  end

  // square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_neg_r [SQRT_STAGES];

  qmfm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c3_vld_r),
    .radicand  (c3_rad_r),
    .out_valid (sq_vld),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    sq_neg_r[0] <= c3_neg_r;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sq_neg_r[i] <= sq_neg_r[i-1];
    end
  end

  // numerator (n - b) << 15, zero when the root falls at or below b
  logic             c4_vld_r;
  logic             c4_neg_r;
  logic [DIV_W-1:0] c4_num_r;
  logic [33:0]      n_q24;

  assign n_q24 = {sq_root, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_vld_r <= 1'b0;
    end else begin
      c4_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    c4_neg_r <= sq_neg_r[SQRT_STAGES-1];
    if (n_q24 <= 34'(curve_b)) begin
      c4_num_r <= '0;
    end else begin
      c4_num_r <= DIV_W'({34'(n_q24 - 34'(curve_b)), 15'd0});
    end
  end

  // divide by a
  logic             dv_vld;
  logic [DIV_W-1:0] dv_quot;
  logic             dv_neg_r [DIV_STAGES];

  qmfm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c4_vld_r),
    .dividend  (c4_num_r),
    .divisor   (DIVR_W'(curve_a)),
    .out_valid (dv_vld),
    .quotient  (dv_quot)
  );

  always_ff @(posedge clk) begin
    dv_neg_r[0] <= c4_neg_r;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dv_neg_r[i] <= dv_neg_r[i-1];
    end
  end

  // saturate
  logic        c5_vld_r;
  logic        c5_neg_r;
  logic [23:0] c5_drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c5_vld_r <= 1'b0;
    end else begin
      c5_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    c5_neg_r   <= dv_neg_r[DIV_STAGES-1];
    c5_drive_r <= (dv_quot > DIV_W'(DRIVE_MAX)) ? DRIVE_MAX : dv_quot[23:0];
  end

  assign out_valid = c5_vld_r;
  assign drive     = c5_drive_r;
  assign clamped   = c5_neg_r;

endmodule

`default_nettype wire

@@ rtl/core/quad_motor_force_mixer.sv @@
// ----------------------------------------------------------------------------
// quad_motor_force_mixer
// X-frame quadrotor mixer: thrust and torques in, four motor commands out.
// ----------------------------------------------------------------------------
// Usage:
//   in_data is taken at a rising edge with start high and busy low. busy is
//   always low: the block is a free-running pipeline and takes one item per
//   clock, back to back.
//   Each result appears on out_data for one cycle with out_valid high.
//   Results leave in order. The path runs through two 56-stage dividers
//   in series (torque by arm or yaw divisor, then curve numerator by a)
//   and the 30-stage square root.
//   The receiver cannot stall; there is no backpressure.
//   Registers are written through cfg_we / cfg_index / cfg_wdata;
//   write them only while no item is in flight.
//   Synchronous reset restores the register defaults and clears all valid
//   bits; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_motor_force_mixer
  import qmfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  assign busy = 1'b0;

  // configuration registers
  logic [15:0] arm_length_r;
  logic [23:0] thrust_to_torque_r;
  logic [23:0] curve_quadratic_r;
  logic [23:0] curve_linear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_length_r       <= ARM_LENGTH_RST;
      thrust_to_torque_r <= THRUST_TO_TORQUE_RST;
      curve_quadratic_r  <= CURVE_QUADRATIC_RST;
      curve_linear_r     <= CURVE_LINEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ARM_LENGTH:       arm_length_r       <= cfg_wdata[15:0];
        REG_THRUST_TO_TORQUE: thrust_to_torque_r <= cfg_wdata;
        REG_CURVE_QUADRATIC:  curve_quadratic_r  <= cfg_wdata;
        REG_CURVE_LINEAR:     curve_linear_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived divisors, zero arm length, thrust-to-torque and quadratic registers act as one
  logic [15:0]       len_eff;
  logic [47:0]       arm_prod;
  logic [DIVR_W-1:0] arm_div_r;
  logic [23:0]       k_eff_r;
  logic [23:0]       a_eff_r;
  logic [BB_W-1:0]   bb8_r;
  logic [47:0]       bb_full;

  assign len_eff  = (arm_length_r == '0) ? 16'd1 : arm_length_r;
  assign arm_prod = 48'(SQRT_HALF_Q32) * 48'(len_eff);
  assign bb_full  = 48'(curve_linear_r) * 48'(curve_linear_r);

  always_ff @(posedge clk) begin
    arm_div_r <= arm_prod[47:16];
    k_eff_r   <= (thrust_to_torque_r == '0) ? 24'd1 : thrust_to_torque_r;
    a_eff_r   <= (curve_quadratic_r == '0) ? 24'd1 : curve_quadratic_r;
    bb8_r     <= bb_full[47:8];
  end

  // input register
  logic     in_vld_r;
  in_item_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // torque magnitudes
  logic [31:0] mag_x;
  logic [31:0] mag_y;
  logic [31:0] mag_z;

  assign mag_x = in_r.torque_x[31] ? 32'(-in_r.torque_x) : 32'(in_r.torque_x);
  assign mag_y = in_r.torque_y[31] ? 32'(-in_r.torque_y) : 32'(in_r.torque_y);
  assign mag_z = in_r.torque_z[31] ? 32'(-in_r.torque_z) : 32'(in_r.torque_z);

  // torque dividers
  logic             dx_vld;
  logic             dy_vld;
  logic             dz_vld;
  logic [DIV_W-1:0] q_x;
  logic [DIV_W-1:0] q_y;
  logic [DIV_W-1:0] q_z;

  qmfm_div u_div_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .dividend  ({mag_x, 24'd0}),
    .divisor   (arm_div_r),
    .out_valid (dx_vld),
    .quotient  (q_x)
  );

  qmfm_div u_div_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .dividend  ({mag_y, 24'd0}),
    .divisor   (arm_div_r),
    .out_valid (dy_vld),
    .quotient  (q_y)
  );

  qmfm_div u_div_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vld_r),
    .dividend  ({8'd0, mag_z, 16'd0}),
    .divisor   (DIVR_W'(k_eff_r)),
    .out_valid (dz_vld),
    .quotient  (q_z)
  );

  // thrust and signs ride alongside the dividers
  logic [23:0] thr_d_r [DIV_STAGES];
  logic [2:0]  sgn_d_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    thr_d_r[0] <= in_r.thrust;
    sgn_d_r[0] <= {in_r.torque_x[31], in_r.torque_y[31], in_r.torque_z[31]};
    for (int i = 1; i < DIV_STAGES; i++) begin
      thr_d_r[i] <= thr_d_r[i-1];
      sgn_d_r[i] <= sgn_d_r[i-1];
    end
  end

  // signed torque parts
  logic                      t2_vld_r;
  logic signed [FORCE_W-1:0] roll_r;
  logic signed [FORCE_W-1:0] pitch_r;
  logic signed [FORCE_W-1:0] yaw_r;
  logic signed [FORCE_W-1:0] thr_r;
  logic signed [FORCE_W-1:0] qx_s;
  logic signed [FORCE_W-1:0] qy_s;
  logic signed [FORCE_W-1:0] qz_s;
  logic [2:0]                sgn;

  assign qx_s = FORCE_W'(q_x);
  assign qy_s = FORCE_W'(q_y);
  assign qz_s = FORCE_W'(q_z);
  assign sgn  = sgn_d_r[DIV_STAGES-1];

  // partial sums
  logic                      t3_vld_r;
  logic signed [FORCE_W-1:0] rp_r;
  logic signed [FORCE_W-1:0] rm_r;
  logic signed [FORCE_W-1:0] typ_r;
  logic signed [FORCE_W-1:0] tym_r;

  // motor forces
  logic                      t4_vld_r;
  logic signed [FORCE_W-1:0] force_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else begin
      t2_vld_r <= dx_vld && dy_vld && dz_vld;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= sgn[2] ? -qx_s : qx_s;
    pitch_r <= sgn[1] ? -qy_s : qy_s;
    yaw_r   <= sgn[0] ? -qz_s : qz_s;
    thr_r   <= FORCE_W'({thr_d_r[DIV_STAGES-1], 6'd0});
    rp_r    <= roll_r + pitch_r;
    rm_r    <= roll_r - pitch_r;
    typ_r   <= thr_r + yaw_r;
    tym_r   <= thr_r - yaw_r;
    force_r[0] <= tym_r - rp_r;
    force_r[1] <= typ_r - rm_r;
    force_r[2] <= tym_r + rp_r;
    force_r[3] <= typ_r + rm_r;
  end

  // curve lanes
  logic        ln_vld [4];
  logic [23:0] ln_drv [4];
  logic [3:0]  ln_clamp;

  for (genvar m = 0; m < 4; m++) begin : g_lane
    qmfm_curve u_curve (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (t4_vld_r),
      .force_in  (force_r[m]),
      .curve_a   (a_eff_r),
      .curve_b   (curve_linear_r),
      .bb8       (bb8_r),
      .out_valid (ln_vld[m]),
      .drive     (ln_drv[m]),
      .clamped   (ln_clamp[m])
    );
  end

  // result
  assign out_valid                  = ln_vld[0] && ln_vld[1] && ln_vld[2] && ln_vld[3];
  assign out_data.drive_front_left  = ln_drv[0];
  assign out_data.drive_rear_left   = ln_drv[1];
  assign out_data.drive_rear_right  = ln_drv[2];
  assign out_data.drive_front_right = ln_drv[3];
  assign out_data.clamped_mask      = ln_clamp;

endmodule

`default_nettype wire
